// ----- rtl/mte_pkg.sv -----
// Shared types and codes of the micro-op template expander.
// Used by the front decoder, the queue, the back executor and the top level.
package mte_pkg;

    localparam int TEMPLATE_DEPTH_DEF = 256;
    localparam int ROW_BITS_DEF       = 16;

    // entries between front and back; a power of two so the pointers wrap freely
    localparam int QUEUE_DEPTH = 2;

    localparam int PROD_W = 17;  // element_size * column

    localparam logic [2:0] OP_NOP             = 3'd0;
    localparam logic [2:0] OP_SUBI            = 3'd1;
    localparam logic [2:0] OP_BNZE            = 3'd2;
    localparam logic [2:0] OP_SET_LOOPCOUNTER = 3'd3;
    localparam logic [2:0] OP_DONE            = 3'd4;
    localparam logic [2:0] OP_RCLONE          = 3'd5;
    localparam logic [2:0] OP_MAJOR           = 3'd6;

    localparam logic [1:0] TGT_BITPOS      = 2'd0;
    localparam logic [1:0] TGT_LOOPCOUNTER = 2'd1;

    localparam logic [1:0] SEL_LITERAL = 2'd0;
    localparam logic [1:0] SEL_A       = 2'd1;
    localparam logic [1:0] SEL_B       = 2'd2;
    localparam logic [1:0] SEL_C       = 2'd3;

    localparam logic [1:0] KIND_CONTROL = 2'd0;
    localparam logic [1:0] KIND_ARITH   = 2'd1;
    localparam logic [1:0] KIND_RCLONE  = 2'd2;
    localparam logic [1:0] KIND_MAJOR   = 2'd3;

    localparam logic [1:0] CFG_ELEMENT_SIZE = 2'd0;
    localparam logic [1:0] CFG_COLUMN_A     = 2'd1;
    localparam logic [1:0] CFG_COLUMN_B     = 2'd2;
    localparam logic [1:0] CFG_COLUMN_C     = 2'd3;

    localparam logic [6:0] ELEMENT_SIZE_RESET = 7'd32;

    typedef struct packed {
        logic [6:0] element_size;
        logic [9:0] column_a;
        logic [9:0] column_b;
        logic [9:0] column_c;
    } t_cfg;

    // one classified template step, as it waits in the queue
    typedef struct packed {
        logic [2:0]        mode;
        logic [1:0]        target;
        logic [15:0]       imm;
        logic [15:0]       br_quot;   // estimate of imm / TEMPLATE_DEPTH, may be one low
        logic              f_res;     // first operand needs bit position added
        logic [PROD_W-1:0] f_base;    // product or literal
        logic              s_res;
        logic [PROD_W-1:0] s_base;
        logic [1:0]        kind;
        logic [1:0]        count;
        logic              bad;
    } t_uop;

endpackage

// ----- rtl/mte_front.sv -----
// Front end: accepts template steps, classifies them and forms operand products.
// Depends on mte_pkg; feeds mte_queue.
module mte_front #(
    parameter int TEMPLATE_DEPTH = mte_pkg::TEMPLATE_DEPTH_DEF
) (
    input  logic               i_valid,
    input  logic               i_full,
    input  mte_pkg::t_cfg      i_cfg,
    input  logic [2:0]         i_mode,
    input  logic [1:0]         i_target,
    input  logic signed [15:0] i_immediate,
    input  logic [1:0]         i_first_select,
    input  logic [15:0]        i_first_literal,
    input  logic               i_second_present,
    input  logic [1:0]         i_second_select,
    input  logic [15:0]        i_second_literal,
    output logic               o_push,
    output mte_pkg::t_uop      o_uop
);
    import mte_pkg::*;

    // reciprocal for the branch target modulo; the estimate is exact or one low
    localparam int BR_SHIFT = 16 + $clog2(TEMPLATE_DEPTH);
    localparam int BR_RECIP = (1 << BR_SHIFT) / TEMPLATE_DEPTH;
    localparam int BR_PW    = 33;

    logic [15:0]       imm_u;
    logic [BR_PW-1:0]  br_prod;
    logic [PROD_W-1:0] f_prod;
    logic [PROD_W-1:0] s_prod;
    logic              f_res;
    logic              s_res;
    logic              tgt_ok;

    function automatic logic [9:0] column_of(logic [1:0] sel, t_cfg cfg);
        logic [9:0] col;
        case (sel)
            SEL_A:   col = cfg.column_a;
            SEL_B:   col = cfg.column_b;
            SEL_C:   col = cfg.column_c;
            default: col = '0;
        endcase
        return col;
    endfunction

    assign o_push = i_valid && !i_full;
    assign imm_u  = i_immediate;

    assign br_prod = BR_PW'(imm_u) * BR_PW'(BR_RECIP);
    assign f_prod  = PROD_W'(i_cfg.element_size) * PROD_W'(column_of(i_first_select, i_cfg));
    assign s_prod  = PROD_W'(i_cfg.element_size) * PROD_W'(column_of(i_second_select, i_cfg));
    assign f_res   = (i_first_select != SEL_LITERAL);
    assign s_res   = (i_second_select != SEL_LITERAL);
    assign tgt_ok  = i_target inside {TGT_BITPOS, TGT_LOOPCOUNTER};

    always_comb begin
        o_uop         = '0;
        o_uop.mode    = i_mode;
        o_uop.target  = i_target;
        o_uop.imm     = imm_u;
        o_uop.br_quot = 16'(br_prod >> BR_SHIFT);
        o_uop.kind    = KIND_CONTROL;
        o_uop.count   = 2'd1;
        case (i_mode)
            OP_NOP, OP_DONE: begin
            end
            OP_SUBI: begin
                o_uop.kind  = KIND_ARITH;
                o_uop.count = 2'd3;
                o_uop.bad   = !tgt_ok;
            end
            OP_BNZE: begin
                o_uop.count = 2'd3;
                o_uop.bad   = !tgt_ok;
            end
            OP_SET_LOOPCOUNTER: begin
                o_uop.count = 2'd2;
            end
            OP_RCLONE: begin
                o_uop.kind   = KIND_RCLONE;
                o_uop.count  = 2'd3;
                o_uop.f_res  = f_res;
                o_uop.f_base = f_res ? f_prod : PROD_W'(i_first_literal);
                o_uop.s_res  = s_res;
                o_uop.s_base = s_res ? s_prod : PROD_W'(i_second_literal);
            end
            OP_MAJOR: begin
                o_uop.kind   = KIND_MAJOR;
                o_uop.count  = i_second_present ? 2'd3 : 2'd2;
                o_uop.f_res  = f_res;
                o_uop.f_base = f_res ? f_prod : PROD_W'(i_first_literal);
                if (i_second_present) begin
                    o_uop.s_res  = s_res;
                    o_uop.s_base = s_res ? s_prod : PROD_W'(i_second_literal);
                end
            end
            default: begin
                o_uop.bad = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/mte_queue.sv -----
// Short queue of classified steps between front and back.
// Depends on mte_pkg for the entry type and depth.
module mte_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mte_pkg::t_uop i_uop,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mte_pkg::t_uop o_uop
);
    import mte_pkg::*;

    localparam int QIDX_W = $clog2(QUEUE_DEPTH);

    t_uop              r_mem [QUEUE_DEPTH];
    logic [QIDX_W-1:0] r_wr_ptr;
    logic [QIDX_W-1:0] r_rd_ptr;
    logic [QIDX_W:0]   r_count;
    logic [QIDX_W:0]   n_count;

    assign o_full  = (r_count == (QIDX_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_uop   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_uop;
        end
    end

endmodule

// ----- rtl/mte_back.sv -----
// Back end: carries out queued steps on bit position, loop counter and pointer,
// resolves rows and holds the result register. Depends on mte_pkg.
module mte_back #(
    parameter int TEMPLATE_DEPTH = mte_pkg::TEMPLATE_DEPTH_DEF,
    parameter int ROW_BITS       = mte_pkg::ROW_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mte_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  mte_pkg::t_uop i_uop,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_uop_kind,
    output logic [15:0]   o_first_row,
    output logic [15:0]   o_second_row,
    output logic [1:0]    o_field_count,
    output logic [7:0]    o_next_pointer,
    output logic          o_program_done,
    output logic          o_bad_template
);
    import mte_pkg::*;

    localparam int PTR_W = $clog2(TEMPLATE_DEPTH);
    localparam int OPW   = (PTR_W < 8) ? PTR_W : 8;
    localparam int OW    = (ROW_BITS < 16) ? ROW_BITS : 16;
    localparam int CW    = (ROW_BITS > 18) ? ROW_BITS : 18;

    logic [7:0]       r_bit_pos;
    logic [15:0]      r_loop;
    logic [PTR_W-1:0] r_ptr;
    logic [7:0]       n_bit_pos;
    logic [15:0]      n_loop;
    logic [PTR_W-1:0] n_ptr;

    logic             r_valid;
    logic [1:0]       r_kind;
    logic [15:0]      r_first_row;
    logic [15:0]      r_second_row;
    logic [1:0]       r_count;
    logic [7:0]       r_next_ptr;
    logic             r_done;
    logic             r_bad;

    logic [PTR_W-1:0] ptr_adv;
    logic [16:0]      br_diff;
    logic [PTR_W:0]   br_rem;
    logic [PTR_W-1:0] br_ptr;
    logic             nz;

    // row = element_size*column + bit_position - 1, modulo 2^ROW_BITS
    function automatic logic [15:0] resolve_row(logic res, logic [PROD_W-1:0] base,
                                                logic [7:0] bp);
        logic [CW-1:0]       sum;
        logic [ROW_BITS-1:0] row;
        sum = CW'(base) + CW'(bp) + {CW{1'b1}};
        row = sum[ROW_BITS-1:0];
        return res ? 16'(row[OW-1:0]) : base[15:0];
    endfunction

    assign o_pop = !i_empty && (!r_valid || !i_stall);

    assign ptr_adv = (r_ptr == PTR_W'(TEMPLATE_DEPTH - 1)) ? '0 : r_ptr + 1'b1;

    // remainder from the queued quotient estimate, below twice the depth
    assign br_diff = 17'(i_uop.imm) - 17'(32'(i_uop.br_quot) * 32'(TEMPLATE_DEPTH));
    assign br_rem  = br_diff[PTR_W:0];
    assign br_ptr  = (br_rem >= (PTR_W + 1)'(TEMPLATE_DEPTH))
                   ? PTR_W'(br_rem - (PTR_W + 1)'(TEMPLATE_DEPTH))
                   : br_rem[PTR_W-1:0];

    assign nz = ((i_uop.target == TGT_BITPOS) && (r_bit_pos != '0))
             || ((i_uop.target == TGT_LOOPCOUNTER) && (r_loop != '0));

    always_comb begin
        n_bit_pos = r_bit_pos;
        n_loop    = r_loop;
        n_ptr     = r_ptr;
        case (i_uop.mode)
            OP_NOP, OP_RCLONE, OP_MAJOR: begin
                n_ptr = ptr_adv;
            end
            OP_SUBI: begin
                if (i_uop.target == TGT_BITPOS) begin
                    n_bit_pos = r_bit_pos - i_uop.imm[7:0];
                end else if (i_uop.target == TGT_LOOPCOUNTER) begin
                    n_loop = r_loop - i_uop.imm;
                end
                n_ptr = ptr_adv;
            end
            OP_BNZE: begin
                n_ptr = nz ? br_ptr : ptr_adv;
            end
            OP_SET_LOOPCOUNTER: begin
                n_loop = i_uop.imm;
                n_ptr  = ptr_adv;
            end
            OP_DONE: begin
                n_bit_pos = 8'(i_cfg.element_size);
                n_loop    = '0;
                n_ptr     = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pos <= 8'(ELEMENT_SIZE_RESET);
            r_loop    <= '0;
            r_ptr     <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_bit_pos <= n_bit_pos;
                r_loop    <= n_loop;
                r_ptr     <= n_ptr;
                r_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind       <= i_uop.kind;
            r_first_row  <= resolve_row(i_uop.f_res, i_uop.f_base, r_bit_pos);
            r_second_row <= resolve_row(i_uop.s_res, i_uop.s_base, r_bit_pos);
            r_count      <= i_uop.count;
            r_next_ptr   <= 8'(n_ptr[OPW-1:0]);
            r_done       <= (i_uop.mode == OP_DONE);
            r_bad        <= i_uop.bad;
        end
    end

    assign o_valid        = r_valid;
    assign o_uop_kind     = r_kind;
    assign o_first_row    = r_first_row;
    assign o_second_row   = r_second_row;
    assign o_field_count  = r_count;
    assign o_next_pointer = r_next_ptr;
    assign o_program_done = r_done;
    assign o_bad_template = r_bad;

endmodule

// ----- rtl/microprogram_template_expander_unit.sv -----
// Template micro-op expander: one result word per accepted step.
// A step accepted on the input is written into the queue, then popped into the back end's result register.
// Throughput one step per cycle while the output is not stalled.
// A stalled output backs up a two-entry queue before the input stalls.
// Synchronous active-low reset clears state and queue and restores config defaults.
module microprogram_template_expander_unit #(
    parameter int TEMPLATE_DEPTH = mte_pkg::TEMPLATE_DEPTH_DEF,
    parameter int ROW_BITS       = mte_pkg::ROW_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic [1:0]         i_target,
    input  logic signed [15:0] i_immediate,
    input  logic [1:0]         i_first_select,
    input  logic [15:0]        i_first_literal,
    input  logic               i_second_present,
    input  logic [1:0]         i_second_select,
    input  logic [15:0]        i_second_literal,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_uop_kind,
    output logic [15:0]        o_first_row,
    output logic [15:0]        o_second_row,
    output logic [1:0]         o_field_count,
    output logic [7:0]         o_next_pointer,
    output logic               o_program_done,
    output logic               o_bad_template
);
    import mte_pkg::*;

    t_cfg r_cfg;
    t_uop front_uop;
    t_uop head_uop;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.element_size <= ELEMENT_SIZE_RESET;
            r_cfg.column_a     <= '0;
            r_cfg.column_b     <= '0;
            r_cfg.column_c     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ELEMENT_SIZE: r_cfg.element_size <= i_cfg_data[6:0];
                CFG_COLUMN_A:     r_cfg.column_a     <= i_cfg_data;
                CFG_COLUMN_B:     r_cfg.column_b     <= i_cfg_data;
                CFG_COLUMN_C:     r_cfg.column_c     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_full;

    mte_front #(
        .TEMPLATE_DEPTH (TEMPLATE_DEPTH)
    ) u_front (
        .i_valid          (i_in_valid),
        .i_full           (q_full),
        .i_cfg            (r_cfg),
        .i_mode           (i_mode),
        .i_target         (i_target),
        .i_immediate      (i_immediate),
        .i_first_select   (i_first_select),
        .i_first_literal  (i_first_literal),
        .i_second_present (i_second_present),
        .i_second_select  (i_second_select),
        .i_second_literal (i_second_literal),
        .o_push           (push),
        .o_uop            (front_uop)
    );

    mte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (front_uop),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_uop   (head_uop)
    );

    mte_back #(
        .TEMPLATE_DEPTH (TEMPLATE_DEPTH),
        .ROW_BITS       (ROW_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (q_empty),
        .i_uop          (head_uop),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_uop_kind     (o_uop_kind),
        .o_first_row    (o_first_row),
        .o_second_row   (o_second_row),
        .o_field_count  (o_field_count),
        .o_next_pointer (o_next_pointer),
        .o_program_done (o_program_done),
        .o_bad_template (o_bad_template)
    );

`ifndef SYNTHESIS
    a_done_clears_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_program_done |->
            (o_next_pointer == '0) && !o_bad_template && (o_uop_kind == KIND_CONTROL))
        else $error("DONE result with nonzero pointer or wrong kind");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_field_count != 2'd0))
        else $error("result with zero field count");

    a_major_no_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_uop_kind == KIND_MAJOR) && (o_field_count == 2'd2) |->
            (o_second_row == '0))
        else $error("single-operand majority carries a second row");

    a_bad_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_template |-> (o_field_count == 2'd3) || (o_field_count == 2'd1))
        else $error("bad template with unexpected field count");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of microprogram_template_expander_unit.
// Predicts every issued micro-op from its own model of the sequencer state and
// compares it with the block's output; depends on mte_pkg and the RTL top only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mte_pkg::*;

    localparam logic [2:0] OP_UNDEFINED = 3'd7;
    localparam logic [1:0] TGT_BAD      = 2'd2;
    localparam logic [1:0] TGT_BAD_HI   = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned PHASE_STEPS  = 130;

    typedef struct {
        logic [2:0]  mode;
        logic [1:0]  target;
        logic [15:0] immediate;
        logic [1:0]  first_select;
        logic [15:0] first_literal;
        logic        second_present;
        logic [1:0]  second_select;
        logic [15:0] second_literal;
    } t_step_word;

    typedef struct packed {
        logic [1:0]  uop_kind;
        logic [15:0] first_row;
        logic [15:0] second_row;
        logic [1:0]  field_count;
        logic [7:0]  next_pointer;
        logic        program_done;
        logic        bad_template;
    } t_issued_uop;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [9:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_mode = '0;
    logic [1:0]         i_target = '0;
    logic signed [15:0] i_immediate = '0;
    logic [1:0]         i_first_select = '0;
    logic [15:0]        i_first_literal = '0;
    logic               i_second_present = 1'b0;
    logic [1:0]         i_second_select = '0;
    logic [15:0]        i_second_literal = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_uop_kind;
    logic [15:0]        o_first_row;
    logic [15:0]        o_second_row;
    logic [1:0]         o_field_count;
    logic [7:0]         o_next_pointer;
    logic               o_program_done;
    logic               o_bad_template;

    microprogram_template_expander_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_target         (i_target),
        .i_immediate      (i_immediate),
        .i_first_select   (i_first_select),
        .i_first_literal  (i_first_literal),
        .i_second_present (i_second_present),
        .i_second_select  (i_second_select),
        .i_second_literal (i_second_literal),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_uop_kind       (o_uop_kind),
        .o_first_row      (o_first_row),
        .o_second_row     (o_second_row),
        .o_field_count    (o_field_count),
        .o_next_pointer   (o_next_pointer),
        .o_program_done   (o_program_done),
        .o_bad_template   (o_bad_template)
    );

    always #2 i_clk = ~i_clk;

    // predicted configuration and sequencer state
    logic [6:0]  elem_size = ELEMENT_SIZE_RESET;
    logic [9:0]  col_a = '0;
    logic [9:0]  col_b = '0;
    logic [9:0]  col_c = '0;
    logic [7:0]  bit_pos = 8'd32;
    logic [15:0] loop_ctr = '0;
    logic [7:0]  tmpl_ptr = '0;

    t_issued_uop pending_uops[$];
    int unsigned mismatch_count = 0;
    int unsigned sent_steps = 0;
    int unsigned cycle_count = 0;
    bit          in_idle_on = 1'b0;
    bit          out_idle_on = 1'b0;
    int unsigned hold_req = 0;
    int unsigned stall_left = 0;

    function automatic int unsigned gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] resolve_row(logic [1:0] sel, logic [15:0] lit);
        logic [31:0] col;
        logic [31:0] sum;
        case (sel)
            SEL_A:   col = 32'(col_a);
            SEL_B:   col = 32'(col_b);
            SEL_C:   col = 32'(col_c);
            default: return lit;
        endcase
        // element_size * column + bit_position - 1, modulo 2^16
        sum = 32'(elem_size) * col + 32'(bit_pos) + 32'hFFFF;
        return sum[15:0];
    endfunction

    function automatic t_issued_uop predict_uop(t_step_word w);
        t_issued_uop r;
        logic        nz;
        r = '0;
        r.field_count = 2'd1;
        nz = 1'b0;
        case (w.mode)
            OP_NOP: begin
                tmpl_ptr = tmpl_ptr + 8'd1;
            end
            OP_SUBI: begin
                r.uop_kind = KIND_ARITH;
                r.field_count = 2'd3;
                if (w.target == TGT_BITPOS)
                    bit_pos = bit_pos - w.immediate[7:0];
                else if (w.target == TGT_LOOPCOUNTER)
                    loop_ctr = loop_ctr - w.immediate;
                else
                    r.bad_template = 1'b1;
                tmpl_ptr = tmpl_ptr + 8'd1;
            end
            OP_BNZE: begin
                r.field_count = 2'd3;
                if (w.target == TGT_BITPOS)
                    nz = (bit_pos != 0);
                else if (w.target == TGT_LOOPCOUNTER)
                    nz = (loop_ctr != 0);
                else
                    r.bad_template = 1'b1;
                tmpl_ptr = nz ? w.immediate[7:0] : tmpl_ptr + 8'd1;
            end
            OP_SET_LOOPCOUNTER: begin
                r.field_count = 2'd2;
                loop_ctr = w.immediate;
                tmpl_ptr = tmpl_ptr + 8'd1;
            end
            OP_DONE: begin
                bit_pos = {1'b0, elem_size};
                loop_ctr = '0;
                tmpl_ptr = '0;
                r.program_done = 1'b1;
            end
            OP_RCLONE: begin
                r.uop_kind = KIND_RCLONE;
                r.field_count = 2'd3;
                r.first_row = resolve_row(w.first_select, w.first_literal);
                r.second_row = resolve_row(w.second_select, w.second_literal);
                tmpl_ptr = tmpl_ptr + 8'd1;
            end
            OP_MAJOR: begin
                r.uop_kind = KIND_MAJOR;
                r.field_count = 2'd2;
                r.first_row = resolve_row(w.first_select, w.first_literal);
                if (w.second_present) begin
                    r.field_count = 2'd3;
                    r.second_row = resolve_row(w.second_select, w.second_literal);
                end
                tmpl_ptr = tmpl_ptr + 8'd1;
            end
            default: begin
                // unknown opcode: pointer holds too
                r.bad_template = 1'b1;
            end
        endcase
        r.next_pointer = tmpl_ptr;
        return r;
    endfunction

    function automatic t_step_word control_word(logic [2:0] mode, logic [1:0] target,
                                                logic [15:0] imm);
        t_step_word w;
        w.mode = mode;
        w.target = target;
        w.immediate = imm;
        w.first_select = 2'($urandom_range(0, 3));
        w.first_literal = 16'($urandom_range(0, 16'hFFFF));
        w.second_present = 1'($urandom_range(0, 1));
        w.second_select = 2'($urandom_range(0, 3));
        w.second_literal = 16'($urandom_range(0, 16'hFFFF));
        return w;
    endfunction

    function automatic t_step_word operand_word(logic [2:0] mode, logic [1:0] fsel,
                                                logic [15:0] flit, logic spres,
                                                logic [1:0] ssel, logic [15:0] slit);
        t_step_word w;
        w = control_word(mode, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)));
        w.first_select = fsel;
        w.first_literal = flit;
        w.second_present = spres;
        w.second_select = ssel;
        w.second_literal = slit;
        return w;
    endfunction

    function automatic t_step_word rand_noise_word();
        logic [2:0] mode;
        logic [1:0] target;
        mode = ($urandom_range(0, 15) == 0) ? OP_UNDEFINED : 3'($urandom_range(0, 6));
        target = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, 1));
        return control_word(mode, target, 16'($urandom_range(0, 16'hFFFF)));
    endfunction

    // one word on the input channel; the expectation is formed at acceptance
    task automatic send_step(t_step_word w);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat (gap_length()) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= w.mode;
        i_target         <= w.target;
        i_immediate      <= w.immediate;
        i_first_select   <= w.first_select;
        i_first_literal  <= w.first_literal;
        i_second_present <= w.second_present;
        i_second_select  <= w.second_select;
        i_second_literal <= w.second_literal;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_uops = {pending_uops, predict_uop(w)};
        sent_steps++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_uops.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_put(logic [1:0] idx, logic [9:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ELEMENT_SIZE: elem_size = data[6:0];
            CFG_COLUMN_A:     col_a = data;
            CFG_COLUMN_B:     col_b = data;
            default:          col_c = data;
        endcase
    endtask

    // only called with the block idle
    task automatic write_settings(logic [9:0] es_word, logic [9:0] ca, logic [9:0] cb,
                                  logic [9:0] cc);
        cfg_put(CFG_ELEMENT_SIZE, es_word);
        cfg_put(CFG_COLUMN_A, ca);
        cfg_put(CFG_COLUMN_B, cb);
        cfg_put(CFG_COLUMN_C, cc);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        // reset settings: element size 32, columns 0
        send_step(control_word(OP_NOP, TGT_BITPOS, 16'h0000));
        send_step(operand_word(OP_RCLONE, SEL_A, 16'h0000, 1'b0, SEL_LITERAL, 16'hFFFF));
        send_step(operand_word(OP_MAJOR, SEL_LITERAL, 16'h0000, 1'b0, SEL_C, 16'h1234));
        send_step(control_word(OP_SUBI, TGT_BITPOS, 16'd32));
        // bit position 0 with column 0: row wraps below zero
        send_step(operand_word(OP_RCLONE, SEL_A, 16'h5555, 1'b1, SEL_B, 16'hAAAA));
        send_step(control_word(OP_SUBI, TGT_BITPOS, 16'd1));
        send_step(control_word(OP_BNZE, TGT_BITPOS, 16'hFF05));
        send_step(control_word(OP_SET_LOOPCOUNTER, TGT_BITPOS, 16'h8000));
        send_step(control_word(OP_BNZE, TGT_LOOPCOUNTER, 16'h7FFF));
        send_step(control_word(OP_NOP, TGT_LOOPCOUNTER, 16'hFFFF));
        send_step(control_word(OP_SUBI, TGT_LOOPCOUNTER, 16'h8000));
        send_step(control_word(OP_BNZE, TGT_LOOPCOUNTER, 16'h0042));
        send_step(control_word(OP_SUBI, TGT_BAD, 16'd5));
        send_step(control_word(OP_BNZE, TGT_BAD_HI, 16'd9));
        send_step(control_word(OP_UNDEFINED, TGT_BITPOS, 16'h7FFF));
        send_step(control_word(OP_SUBI, TGT_LOOPCOUNTER, 16'hFFFF));
        send_step(control_word(OP_DONE, TGT_BAD_HI, 16'hFFFF));
        send_step(operand_word(OP_MAJOR, SEL_C, 16'hFFFF, 1'b1, SEL_B, 16'h0000));
        drain();
        // upper data bits beyond the element size field are dropped
        write_settings(10'h3C0, 10'd1023, 10'd1023, 10'd512);
        send_step(operand_word(OP_RCLONE, SEL_A, 16'h0000, 1'b1, SEL_C, 16'h0000));
        send_step(operand_word(OP_MAJOR, SEL_B, 16'h0000, 1'b1, SEL_A, 16'h0000));
        send_step(control_word(OP_SUBI, TGT_BITPOS, 16'h8000));
        send_step(control_word(OP_DONE, TGT_BITPOS, 16'h0000));
        send_step(operand_word(OP_RCLONE, SEL_A, 16'h0000, 1'b0, SEL_LITERAL, 16'h0000));
        drain();
        write_settings(10'd0, 10'd1, 10'd2, 10'd3);
        send_step(operand_word(OP_RCLONE, SEL_B, 16'h0000, 1'b1, SEL_C, 16'h0000));
        send_step(control_word(OP_DONE, TGT_LOOPCOUNTER, 16'h0000));
        send_step(operand_word(OP_MAJOR, SEL_A, 16'h0000, 1'b1, SEL_C, 16'h0000));
        drain();
    endtask

    // loop-shaped template: load, body, decrement, branch back until zero
    task automatic run_loop_program();
        int unsigned body_len;
        logic [7:0]  loop_top;
        logic [1:0]  op_sel;
        send_step(control_word(OP_SET_LOOPCOUNTER, 2'($urandom_range(0, 3)),
                               16'($urandom_range(1, 4))));
        loop_top = tmpl_ptr;
        body_len = $urandom_range(1, 3);
        do begin
            repeat (body_len) begin
                op_sel = 2'($urandom_range(0, 1));
                send_step(operand_word(op_sel[0] ? OP_MAJOR : OP_RCLONE,
                                       2'($urandom_range(0, 3)),
                                       16'($urandom_range(0, 16'hFFFF)),
                                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                       16'($urandom_range(0, 16'hFFFF))));
            end
            send_step(control_word(OP_SUBI, TGT_BITPOS, 16'd1));
            if ($urandom_range(0, 4) == 0)
                send_step(control_word(OP_BNZE, TGT_BITPOS,
                                       16'($urandom_range(0, 16'hFFFF))));
            send_step(control_word(OP_SUBI, TGT_LOOPCOUNTER, 16'd1));
            send_step(control_word(OP_BNZE, TGT_LOOPCOUNTER,
                                   {8'($urandom_range(0, 255)), loop_top}));
        end while (loop_ctr != 0);
        if ($urandom_range(0, 3) == 0)
            send_step(control_word(OP_DONE, 2'($urandom_range(0, 3)),
                                   16'($urandom_range(0, 16'hFFFF))));
    endtask

    task automatic test_random_programs();
        int unsigned phase;
        int unsigned start;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_settings(10'd1, 10'd0, 10'd0, 10'd0);
                1: write_settings({3'($urandom_range(0, 7)), 7'd64}, 10'd1023, 10'd1023,
                                  10'd1023);
                2: write_settings(10'd0, 10'($urandom_range(0, 1023)),
                                  10'($urandom_range(0, 1023)),
                                  10'($urandom_range(0, 1023)));
                3: write_settings(10'd127, 10'($urandom_range(0, 1023)),
                                  10'($urandom_range(0, 1023)),
                                  10'($urandom_range(0, 1023)));
                default: write_settings(10'($urandom_range(1, 64)),
                                        10'($urandom_range(0, 1023)),
                                        10'($urandom_range(0, 1023)),
                                        10'($urandom_range(0, 1023)));
            endcase
            in_idle_on = (phase != 1);
            out_idle_on = (phase != 1) && (phase != 3);
            start = sent_steps;
            while (sent_steps - start < PHASE_STEPS) begin
                if ($urandom_range(0, 9) < 7)
                    run_loop_program();
                else
                    send_step(rand_noise_word());
            end
            // sender pauses here until every expected word is back
            drain();
        end
    endtask

    task automatic test_backpressure();
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        hold_req = 100;
        repeat (30) send_step(rand_noise_word());
        out_idle_on = 1'b1;
        hold_req = 60;
        repeat (20) run_loop_program();
        drain();
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req > 0) begin
            stall_left = hold_req - 1;
            hold_req = 0;
            i_out_stall <= 1'b1;
        end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = gap_length() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_issued_uop got;
        t_issued_uop want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.uop_kind     = o_uop_kind;
            got.first_row    = o_first_row;
            got.second_row   = o_second_row;
            got.field_count  = o_field_count;
            got.next_pointer = o_next_pointer;
            got.program_done = o_program_done;
            got.bad_template = o_bad_template;
            if (pending_uops.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: kind=%0d first=%h second=%h",
                             got.uop_kind, got.first_row, got.second_row);
            end else begin
                want = pending_uops.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: kind %0d/%0d first %h/%h second %h/%h ",
                                  "count %0d/%0d ptr %0d/%0d done %b/%b bad %b/%b ",
                                  "(expected/actual)"},
                                 want.uop_kind, got.uop_kind, want.first_row, got.first_row,
                                 want.second_row, got.second_row, want.field_count,
                                 got.field_count, want.next_pointer, got.next_pointer,
                                 want.program_done, got.program_done, want.bad_template,
                                 got.bad_template);
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_programs();
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_uops.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mte_pkg.sv
rtl/mte_front.sv
rtl/mte_queue.sv
rtl/mte_back.sv
rtl/microprogram_template_expander_unit.sv
test/testbench.sv
